### design/rti_pkg.sv
`default_nettype none
package rti_pkg;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 31;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_MIN_DET  = 3'd6;
    // quotient bits produced by the divider chain (u, v: 16, t: 22 + headroom)
    localparam int TFracBits  = 22;
    localparam int UvFracBits = 16;
    localparam int DivSteps   = 33;
    localparam int DenW       = 52;

    typedef struct packed {
        logic                 live;
        logic                 hit;
        logic                 tneg;
        logic                 tsat;
        logic [DenW-1:0]      den;
        logic [DenW:0]        rem_t;
        logic [DenW:0]        rem_u;
        logic [DenW:0]        rem_v;
        logic [DivSteps-1:0]  q_t;
        logic [UvFracBits:0]  q_u;
        logic [UvFracBits:0]  q_v;
    } div_word_t;
endpackage
`default_nettype wire

### design/ray_triangle_intersect.sv
`default_nettype none
// Moller-Trumbore ray/triangle test, one triangle word per cycle against the ray held in the
// configuration registers. The pipeline is 4 arithmetic stages, a row of 32 restoring-divider
// cells (one quotient bit of t per cell, and of u and v in the first 16 cells) and one output register. All
// stages advance together and stall only when the output register is full and not taken.
module ray_triangle_intersect #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z
    input  wire logic [143:0]                  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hit, distance, bary_u, bary_v, zero pad
    output logic [71:0]                        m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [rti_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [rti_pkg::CfgDataW-1:0]  cfg_data
);
    localparam int N = rti_pkg::DivSteps - 1;

    logic [15:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic [30:0] md_reg;
    logic        en;
    logic        out_v_reg;
    logic [66:0] out_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
            dx_reg <= '0; dy_reg <= '0; dz_reg <= 16'd16384;
            md_reg <= 31'd107374;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rti_pkg::REG_ORIGIN_X: ox_reg <= cfg_data[15:0];
                rti_pkg::REG_ORIGIN_Y: oy_reg <= cfg_data[15:0];
                rti_pkg::REG_ORIGIN_Z: oz_reg <= cfg_data[15:0];
                rti_pkg::REG_DIR_X:    dx_reg <= cfg_data[15:0];
                rti_pkg::REG_DIR_Y:    dy_reg <= cfg_data[15:0];
                rti_pkg::REG_DIR_Z:    dz_reg <= cfg_data[15:0];
                rti_pkg::REG_MIN_DET:  md_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rti_pkg::div_word_t chain [N+1];

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    rti_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_live(s_tvalid),
        .verts(s_tdata), .orig({oz_reg, oy_reg, ox_reg}), .dir({dz_reg, dy_reg, dx_reg}),
        .min_det(md_reg), .dout(chain[0])
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        rti_div_cell #(.STEP(i)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en), .din(chain[i]), .dout(chain[i+1])
        );
    end

    rti_pkg::div_word_t last;
    logic [31:0] mag_t, t_fix;
    logic [16:0] bu, bv;
    always_comb begin
        last  = chain[N];
        mag_t = last.q_t[31:0];
        if (last.tneg) begin
            t_fix = (last.tsat || mag_t > 32'h8000_0000) ? 32'h8000_0000 : 32'(-mag_t);
        end else begin
            t_fix = (last.tsat || mag_t > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_t;
        end
        bu = (last.q_u > 17'd65536) ? 17'd65536 : last.q_u;
        bv = (last.q_v > 17'd65536) ? 17'd65536 : last.q_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= last.live;
            out_d_reg <= last.hit ? {bv, bu, t_fix, 1'b1} : '0;
        end
    end
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'b0, out_d_reg};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[70:1] == '0) else $error("miss not zero");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("stall without result");
endmodule
`default_nettype wire

### design/rti_div_cell.sv
`default_nettype none
module rti_div_cell #(
    parameter int STEP = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire rti_pkg::div_word_t   din,
    output rti_pkg::div_word_t        dout
);
    localparam int W = rti_pkg::DenW;
    rti_pkg::div_word_t word_next, dout_reg;
    logic [W:0] sh_t, sh_u, sh_v;

    always_comb begin
        word_next = din;
        sh_t = {din.rem_t[W-1:0], din.q_t[rti_pkg::DivSteps-1]};
        sh_u = {din.rem_u[W-1:0], 1'b0};
        sh_v = {din.rem_v[W-1:0], 1'b0};
        if (sh_t >= {1'b0, din.den}) begin
            word_next.rem_t = sh_t - {1'b0, din.den};
            word_next.q_t   = {din.q_t[rti_pkg::DivSteps-2:0], 1'b1};
        end else begin
            word_next.rem_t = sh_t;
            word_next.q_t   = {din.q_t[rti_pkg::DivSteps-2:0], 1'b0};
        end
        if (STEP < rti_pkg::UvFracBits) begin
            if (sh_u >= {1'b0, din.den}) begin
                word_next.rem_u = sh_u - {1'b0, din.den};
                word_next.q_u   = {din.q_u[rti_pkg::UvFracBits-1:0], 1'b1};
            end else begin
                word_next.rem_u = sh_u;
                word_next.q_u   = {din.q_u[rti_pkg::UvFracBits-1:0], 1'b0};
            end
            if (sh_v >= {1'b0, din.den}) begin
                word_next.rem_v = sh_v - {1'b0, din.den};
                word_next.q_v   = {din.q_v[rti_pkg::UvFracBits-1:0], 1'b1};
            end else begin
                word_next.rem_v = sh_v;
                word_next.q_v   = {din.q_v[rti_pkg::UvFracBits-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg.live <= 1'b0;
        end else if (en) begin
            dout_reg <= word_next;
        end
    end
    assign dout = dout_reg;
endmodule
`default_nettype wire

### design/rti_front.sv
`default_nettype none
module rti_front #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_live,
    input  wire logic [143:0]         verts,
    input  wire logic [47:0]          orig,
    input  wire logic [47:0]          dir,
    input  wire logic [30:0]          min_det,
    output rti_pkg::div_word_t        dout
);
    localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int W  = rti_pkg::DenW;
    localparam int TIntBits = rti_pkg::DivSteps - 1 - rti_pkg::TFracBits;

    function automatic logic signed [17:0] sx(input logic [15:0] x);
        logic signed [15:0] t;
        t = $signed(x << (16 - CW)) >>> (16 - CW);
        return 18'(t);
    endfunction

    // stage 1: edges, tvec candidates
    logic signed [17:0] e1_reg [3], e2_reg [3], tv_reg [3], d_reg [3];
    logic               l1_reg;
    // stage 2: pvec, qvec (sign-free forms)
    logic signed [35:0] pv_reg [3], qa_reg [3], qb_reg [3];
    logic signed [17:0] e1b_reg [3], e2b_reg [3], tvb_reg [3], db_reg [3];
    logic               l2_reg;
    // stage 3: det, raw u, v, t
    logic signed [55:0] det_reg, u_reg, v_reg, tn_reg;
    logic               l3_reg;
    // stage 4: fold and checks, t saturation check and divider set-up
    rti_pkg::div_word_t w_reg;

    logic signed [35:0] qv [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qv[k] = qa_reg[k] - qb_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg <= 1'b0;
            l2_reg <= 1'b0;
            l3_reg <= 1'b0;
        end else if (en) begin
            l1_reg <= in_live;
            for (int k = 0; k < 3; k++) begin
                e1_reg[k] <= sx(verts[48+16*k +: 16]) - sx(verts[16*k +: 16]);
                e2_reg[k] <= sx(verts[96+16*k +: 16]) - sx(verts[16*k +: 16]);
                tv_reg[k] <= sx(orig[16*k +: 16]) - sx(verts[16*k +: 16]);
                d_reg[k]  <= 18'($signed(dir[16*k +: 16]));
            end
            l2_reg <= l1_reg;
            pv_reg[0] <= d_reg[1]*e2_reg[2] - d_reg[2]*e2_reg[1];
            pv_reg[1] <= d_reg[2]*e2_reg[0] - d_reg[0]*e2_reg[2];
            pv_reg[2] <= d_reg[0]*e2_reg[1] - d_reg[1]*e2_reg[0];
            qa_reg[0] <= tv_reg[1]*e1_reg[2]; qb_reg[0] <= tv_reg[2]*e1_reg[1];
            qa_reg[1] <= tv_reg[2]*e1_reg[0]; qb_reg[1] <= tv_reg[0]*e1_reg[2];
            qa_reg[2] <= tv_reg[0]*e1_reg[1]; qb_reg[2] <= tv_reg[1]*e1_reg[0];
            e1b_reg <= e1_reg; e2b_reg <= e2_reg; tvb_reg <= tv_reg; db_reg <= d_reg;
            l3_reg <= l2_reg;
            det_reg <= 56'(e1b_reg[0]*pv_reg[0]) + 56'(e1b_reg[1]*pv_reg[1])
                       + 56'(e1b_reg[2]*pv_reg[2]);
            u_reg   <= 56'(tvb_reg[0]*pv_reg[0]) + 56'(tvb_reg[1]*pv_reg[1])
                       + 56'(tvb_reg[2]*pv_reg[2]);
            v_reg   <= 56'(db_reg[0]*qv[0]) + 56'(db_reg[1]*qv[1]) + 56'(db_reg[2]*qv[2]);
            tn_reg  <= 56'(e2b_reg[0]*qv[0]) + 56'(e2b_reg[1]*qv[1])
                       + 56'(e2b_reg[2]*qv[2]);
        end
    end

    // sign folding: tvec flips with det, so u, v, t flip too
    logic               pos;
    logic signed [55:0] adet, fu, fv, ft;
    logic [55:0]        at;
    logic               ok;
    always_comb begin
        pos  = det_reg > 0;
        adet = pos ? det_reg : -det_reg;
        fu   = pos ? u_reg  : -u_reg;
        fv   = pos ? v_reg  : -v_reg;
        ft   = pos ? tn_reg : -tn_reg;
        at   = ft[55] ? 56'(-ft) : 56'(ft);
        ok   = (adet != 0) && (adet >= 56'($unsigned(min_det)))
               && !fu[55] && (fu <= adet) && !fv[55] && (fu + fv <= adet);
    end

    // t: integer part must stay below 2^10 (plus sign room) else saturate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg.live <= 1'b0;
        end else if (en) begin
            w_reg.live  <= l3_reg;
            w_reg.hit   <= ok;
            w_reg.tneg  <= ft[55];
            w_reg.tsat  <= (at >> TIntBits) >= adet;
            w_reg.den   <= adet[W-1:0];
            w_reg.rem_t <= (W+1)'(at >> TIntBits);
            w_reg.rem_u <= (fu == adet) ? '0 : (W+1)'(fu);
            w_reg.rem_v <= (fv == adet) ? '0 : (W+1)'(fv);
            w_reg.q_t   <= {at[TIntBits-1:0], {(rti_pkg::DivSteps-TIntBits){1'b0}}};
            w_reg.q_u   <= (rti_pkg::UvFracBits+1)'(fu == adet);
            w_reg.q_v   <= (rti_pkg::UvFracBits+1)'(fv == adet);
        end
    end
    assign dout = w_reg;
endmodule
`default_nettype wire

### tb/ray_triangle_intersect_tb.sv
`default_nettype none
module ray_triangle_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit        hit;
        bit [31:0] distance;
        bit [16:0] bary_u;
        bit [16:0] bary_v;
    } crossing_t;

    class crossing_board;
        longint    orig[3];
        longint    dir[3];
        longint    det_floor;
        crossing_t pending[$];
        int        errors;

        function new();
            orig = '{0, 0, 0};
            dir = '{0, 0, 16384};
            det_floor = 107374;
            errors = 0;
        endfunction

        function void set_reg(logic [rti_pkg::CfgIdxW-1:0] idx,
                              logic [rti_pkg::CfgDataW-1:0] val);
            unique case (idx)
                rti_pkg::REG_ORIGIN_X: orig[0] = longint'($signed(val[15:0]));
                rti_pkg::REG_ORIGIN_Y: orig[1] = longint'($signed(val[15:0]));
                rti_pkg::REG_ORIGIN_Z: orig[2] = longint'($signed(val[15:0]));
                rti_pkg::REG_DIR_X:    dir[0] = longint'($signed(val[15:0]));
                rti_pkg::REG_DIR_Y:    dir[1] = longint'($signed(val[15:0]));
                rti_pkg::REG_DIR_Z:    dir[2] = longint'($signed(val[15:0]));
                rti_pkg::REG_MIN_DET:  det_floor = longint'(val);
                default: ;
            endcase
        endfunction

        // floor(n * 2^fb / d) capped
        function longint unsigned scaled_quot(longint unsigned n, longint unsigned d, int fb,
                                              longint unsigned cap);
            longint unsigned q, r;
            q = n / d;
            r = n % d;
            if (q > (cap >> fb)) return cap;
            for (int i = 0; i < fb; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
            end
            return (q > cap) ? cap : q;
        endfunction

        function void note_triangle(logic [143:0] w);
            longint    p0[3], e1[3], e2[3], pv[3], tv[3], qv[3];
            longint    det, u, v, tn;
            longint unsigned mag;
            crossing_t c;
            c = '{0, 0, 0, 0};
            for (int k = 0; k < 3; k++) begin
                p0[k] = longint'($signed(w[16*k +: 16]));
                e1[k] = longint'($signed(w[16*(3+k) +: 16])) - p0[k];
                e2[k] = longint'($signed(w[16*(6+k) +: 16])) - p0[k];
            end
            pv[0] = dir[1] * e2[2] - dir[2] * e2[1];
            pv[1] = dir[2] * e2[0] - dir[0] * e2[2];
            pv[2] = dir[0] * e2[1] - dir[1] * e2[0];
            det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
            for (int k = 0; k < 3; k++) tv[k] = (det > 0) ? orig[k] - p0[k] : p0[k] - orig[k];
            if (det <= 0) det = -det;
            if (det != 0 && det >= det_floor) begin
                u = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
                qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
                qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
                qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
                v = dir[0] * qv[0] + dir[1] * qv[1] + dir[2] * qv[2];
                if (u >= 0 && u <= det && v >= 0 && u + v <= det) begin
                    tn = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
                    if (tn < 0) begin
                        mag = scaled_quot(longint'(-tn), det, 22, 64'h8000_0000);
                        c.distance = 32'(-mag);
                    end else begin
                        c.distance = 32'(scaled_quot(tn, det, 22, 64'h7fff_ffff));
                    end
                    c.hit = 1;
                    c.bary_u = 17'(scaled_quot(u, det, 16, 65536));
                    c.bary_v = 17'(scaled_quot(v, det, 16, 65536));
                end
            end
            pending = {pending, c};
        endfunction

        function void check_result(logic [71:0] w);
            crossing_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w[0] !== e.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, e.hit, w[0]);
                errors++;
            end
            if (w[32:1] !== e.distance) begin
                $display("%0t: distance expected %h actual %h", $time, e.distance, w[32:1]);
                errors++;
            end
            if (w[49:33] !== e.bary_u) begin
                $display("%0t: bary_u expected %h actual %h", $time, e.bary_u, w[49:33]);
                errors++;
            end
            if (w[66:50] !== e.bary_v) begin
                $display("%0t: bary_v expected %h actual %h", $time, e.bary_v, w[66:50]);
                errors++;
            end
            if (w[71:67] !== 5'd0) begin
                $display("%0t: pad expected 0 actual %h", $time, w[71:67]);
                errors++;
            end
        endfunction
    endclass

    // index with no register behind it
    localparam logic [rti_pkg::CfgIdxW-1:0] REG_NONE = 3'd7;

    logic                         aclk = 0;
    logic                         aresetn = 0;
    logic                         s_tvalid = 0;
    logic                         s_tready;
    logic [143:0]                 s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 0;
    logic [71:0]                  m_tdata;
    logic                         cfg_we = 0;
    logic [rti_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [rti_pkg::CfgDataW-1:0] cfg_data = '0;

    crossing_board board = new();
    int burst_left = 0;

    ray_triangle_intersect dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // receiver stall pattern, mode changes at random among four patterns
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 3);
        unique case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_cnt % 8) < 5;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    initial begin
        #10ms;
        $display("ray_triangle_intersect_tb failed");
        $finish;
    end

    task automatic write_reg(logic [rti_pkg::CfgIdxW-1:0] idx,
                             logic [rti_pkg::CfgDataW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_triangle(logic [143:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge aclk); while (!s_tready);
        board.note_triangle(w);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    function automatic logic [15:0] clamp16(longint x);
        if (x > 32767) return 16'h7fff;
        if (x < -32768) return 16'h8000;
        return 16'(x);
    endfunction

    // triangle around a point on the ray, so a good share of them are crossed
    function automatic logic [143:0] ray_triangle();
        logic [143:0] w;
        longint t, r, pt;
        t = longint'($urandom_range(0, 200)) - 40;
        r = (64'd1 << $urandom_range(2, 11));
        for (int k = 0; k < 3; k++) begin
            pt = board.orig[k] + (board.dir[k] * t) / 64;
            for (int j = 0; j < 3; j++)
                w[16*(3*j+k) +: 16] = clamp16(pt + longint'($urandom_range(0, 2*r)) - r);
        end
        return w;
    endfunction

    function automatic logic [143:0] noise_triangle();
        logic [143:0] w;
        for (int j = 0; j < 9; j++) w[16*j +: 16] = 16'($urandom);
        return w;
    endfunction

    function automatic logic [143:0] tri9(int a0, int a1, int a2, int b0, int b1, int b2,
                                          int c0, int c1, int c2);
        return {16'(c2), 16'(c1), 16'(c0), 16'(b2), 16'(b1), 16'(b0),
                16'(a2), 16'(a1), 16'(a0)};
    endfunction

    initial begin
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset ray: origin 0, direction +z
        send_triangle(tri9(-256, -256, 256, 256, -256, 256, -256, 256, 256));
        send_triangle(tri9(-256, -256, 256, -256, 256, 256, 256, -256, 256));
        send_triangle(tri9(-256, -256, -256, 256, -256, -256, -256, 256, -256));
        send_triangle(tri9(256, 256, 256, 512, 256, 256, 256, 512, 256));
        send_triangle(tri9(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(tri9(1, 0, 5, 2, 0, 5, 3, 0, 5));
        send_triangle(tri9(0, 0, 256, 256, 0, 256, 0, 256, 256));
        send_triangle(tri9(-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 32767));
        send_triangle(tri9(32767, 32767, -32768, -32768, 32767, -32768, 32767, -32768, 32767));
        send_triangle(tri9(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_triangle(tri9(-3, -3, 100, 3, -3, 100, -3, 3, 100));
        drain();

        // zero threshold, degenerate det still a miss
        write_reg(rti_pkg::REG_MIN_DET, '0);
        write_reg(REG_NONE, 31'h7fff_ffff);
        send_triangle(tri9(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(tri9(5, 5, 5, 10, 10, 10, 20, 20, 20));
        send_triangle(tri9(0, 0, 1, 1, 0, 1, 0, 1, 1));
        drain();

        // tiny direction for far hits, saturation both ways
        write_reg(rti_pkg::REG_DIR_Z, 31'd1);
        send_triangle(tri9(-256, -256, 32767, 256, -256, 32767, -256, 256, 32767));
        send_triangle(tri9(-256, -256, -32768, 256, -256, -32768, -256, 256, -32768));
        drain();

        // extremes of origin and direction, top threshold
        write_reg(rti_pkg::REG_ORIGIN_X, 31'h8000);
        write_reg(rti_pkg::REG_ORIGIN_Y, 31'h7fff);
        write_reg(rti_pkg::REG_ORIGIN_Z, 31'h8000);
        write_reg(rti_pkg::REG_DIR_X, 31'h8000);
        write_reg(rti_pkg::REG_DIR_Y, 31'd16384);
        write_reg(rti_pkg::REG_DIR_Z, 31'h7fff_c000);
        write_reg(rti_pkg::REG_MIN_DET, 31'h7fff_ffff);
        for (int i = 0; i < 4; i++) send_triangle(noise_triangle());
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(rti_pkg::REG_ORIGIN_X, 31'($urandom_range(0, 1) ? 16'($urandom)
                                             : 16'($urandom_range(0, 2048) - 1024)));
            write_reg(rti_pkg::REG_ORIGIN_Y, 31'($urandom_range(0, 1) ? 16'($urandom)
                                             : 16'($urandom_range(0, 2048) - 1024)));
            write_reg(rti_pkg::REG_ORIGIN_Z, 31'($urandom_range(0, 2048) - 1024));
            write_reg(rti_pkg::REG_DIR_X, 31'(16'($urandom_range(0, 32768) - 16384)));
            write_reg(rti_pkg::REG_DIR_Y, 31'(16'($urandom_range(0, 32768) - 16384)));
            write_reg(rti_pkg::REG_DIR_Z, 31'(ph == 3 ? 16'($urandom_range(1, 4))
                                            : 16'($urandom_range(0, 32768) - 16384)));
            unique case (ph % 3)
                0: write_reg(rti_pkg::REG_MIN_DET, '0);
                1: write_reg(rti_pkg::REG_MIN_DET, 31'($urandom_range(0, 200000)));
                default: write_reg(rti_pkg::REG_MIN_DET, 31'($urandom));
            endcase
            n = $urandom_range(45, 75);
            for (int i = 0; i < n; i++)
                send_triangle($urandom_range(0, 4) == 0 ? noise_triangle() : ray_triangle());
            drain();
        end

        drain();
        if (board.errors == 0) begin
            $display("ray_triangle_intersect_tb passed");
        end else begin
            $display("ray_triangle_intersect_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
